>>> hw/rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants for the stepper position controller: word
// layouts, action codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

   localparam int unsigned SPC_STEPS_PER_MM = 50;

   localparam int unsigned POS_W    = 16;
   localparam int unsigned CSR_W    = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned DIST_W   = 8;
   localparam int unsigned HEIGHT_W = 8;

   localparam logic [1:0] ACTION_TICK = 2'd0;
   localparam logic [1:0] ACTION_HOME = 2'd1;
   localparam logic [1:0] ACTION_MOVE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_TOP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_HIGH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HEIGHT  = 2'd2;

   localparam logic [CSR_W-1:0] PERIOD_TOP_RESET = 16'd312;
   localparam logic [CSR_W-1:0] PULSE_HIGH_RESET = 16'd156;
   localparam logic [CSR_W-1:0] MAX_HEIGHT_RESET = 16'd10000;

   typedef struct packed {
      logic [1:0]        action;
      logic              move_down;
      logic [DIST_W-1:0] distance_mm;
      logic              limit_switch;
   } req_word_type;

   typedef struct packed {
      logic                step_out;
      logic                dir_out;
      logic                driver_awake;
      logic                busy_res;
      logic [POS_W-1:0]    position_steps;
      logic [HEIGHT_W-1:0] height_mm;
   } rsp_word_type;

endpackage

`default_nettype wire

>>> hw/rtl/spc_height.sv
// ----------------------------------------------------------------------------
// spc_height
// Position in steps to height in millimetres, saturated to eight bits.
// Division by the constant steps-per-mm through a rounded-up reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_height #(
   parameter int unsigned STEPS_PER_MM = spc_pkg::SPC_STEPS_PER_MM
) (
   input  wire logic [spc_pkg::POS_W-1:0]    position,
   output logic      [spc_pkg::HEIGHT_W-1:0] height_mm
);
   import spc_pkg::*;

   localparam int unsigned SHIFT = POS_W + $clog2(STEPS_PER_MM);
   localparam longint unsigned MULT =
      ((64'd1 << SHIFT) + STEPS_PER_MM - 1) / STEPS_PER_MM;
   localparam int unsigned MULT_W = POS_W + 1;
   localparam int unsigned PROD_W = POS_W + MULT_W + 1;

   logic [MULT_W-1:0] mult_c;
   logic [PROD_W-1:0] product;
   logic [PROD_W-1:0] quotient;

   assign mult_c   = MULT_W'(MULT);
   assign product  = PROD_W'(position) * PROD_W'(mult_c);
   assign quotient = product >> SHIFT;

   assign height_mm = (quotient > PROD_W'((1 << HEIGHT_W) - 1))
                      ? {HEIGHT_W{1'b1}} : quotient[HEIGHT_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/stepper_position_controller_core.sv
// ----------------------------------------------------------------------------
// stepper_position_controller_core
// Step/direction stepper controller: homing, millimetre moves, step pulse
// timing and position tracking, one request word per tick or command.
// ----------------------------------------------------------------------------
// path: request accept, input register, response register, then the earliest response accept
// throughput: one request word per cycle while the response side is not stalled
// an input register and a response register decouple the two handshakes
// reset: synchronous, registers back to 312/156/10000, motion idle, position 0
`default_nettype none

module stepper_position_controller_core #(
   parameter int unsigned STEPS_PER_MM = spc_pkg::SPC_STEPS_PER_MM
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire spc_pkg::req_word_type          req_word,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output spc_pkg::rsp_word_type               rsp_word,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [spc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [spc_pkg::CSR_W-1:0]      csr_data
);
   import spc_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_HOME = 2'd1,
      MODE_MOVE = 2'd2
   } motion_mode_type;

   logic [CSR_W-1:0] period_top_ff;
   logic [CSR_W-1:0] pulse_high_ff;
   logic [CSR_W-1:0] max_height_ff;

   logic          in_valid_ff;
   req_word_type  in_word_ff;
   logic          out_valid_ff;
   rsp_word_type  out_word_ff;

   motion_mode_type  mode_ff,   mode_in;
   logic [POS_W-1:0] tick_ff,   tick_in;
   logic [POS_W-1:0] pos_ff,    pos_in;
   logic [POS_W-1:0] target_ff, target_in;
   logic             dir_ff,    dir_in;
   logic             step_in;

   logic             advance;
   logic [POS_W-1:0] move_steps;
   logic [POS_W:0]   up_sum;
   logic [POS_W-1:0] pos_tick;
   logic [HEIGHT_W-1:0] height_in;
   rsp_word_type     rsp_in;

   function automatic logic move_done(input logic dir, input logic [POS_W-1:0] pos,
                                      input logic [POS_W-1:0] tgt,
                                      input logic [POS_W-1:0] top);
      if (!dir) begin
         return !(pos < tgt && pos < top);
      end
      return !(pos > tgt && pos != '0);
   endfunction

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   assign move_steps = POS_W'(in_word_ff.distance_mm * STEPS_PER_MM);
   assign up_sum     = {1'b0, pos_ff} + {1'b0, move_steps};
   assign pos_tick   = dir_ff ? pos_ff - 1'b1 : pos_ff + 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      tick_in   = tick_ff;
      pos_in    = pos_ff;
      target_in = target_ff;
      dir_in    = dir_ff;
      step_in   = 1'b0;
      if (mode_ff == MODE_IDLE) begin
         if (in_word_ff.action == ACTION_HOME) begin
            dir_in  = 1'b1;
            tick_in = '0;
            if (in_word_ff.limit_switch) begin
               pos_in = '0;
            end else begin
               mode_in = MODE_HOME;
            end
         end else if (in_word_ff.action == ACTION_MOVE) begin
            dir_in  = in_word_ff.move_down;
            tick_in = '0;
            if (!in_word_ff.move_down) begin
               target_in = up_sum[POS_W] ? {POS_W{1'b1}} : up_sum[POS_W-1:0];
            end else begin
               target_in = (move_steps >= pos_ff) ? '0 : pos_ff - move_steps;
            end
            mode_in = move_done(dir_in, pos_ff, target_in, max_height_ff)
                      ? MODE_IDLE : MODE_MOVE;
         end
      end else if (in_word_ff.action == ACTION_TICK) begin
         if (mode_ff == MODE_HOME && in_word_ff.limit_switch) begin
            pos_in  = '0;
            mode_in = MODE_IDLE;
            tick_in = '0;
         end else begin
            step_in = tick_ff < pulse_high_ff;
            if (tick_ff >= period_top_ff) begin
               tick_in = '0;
               pos_in  = pos_tick;
               if (mode_ff == MODE_MOVE &&
                   move_done(dir_ff, pos_tick, target_ff, max_height_ff)) begin
                  mode_in = MODE_IDLE;
               end
            end else begin
               tick_in = tick_ff + 1'b1;
            end
         end
      end
   end

   spc_height #(
      .STEPS_PER_MM (STEPS_PER_MM)
   ) u_height (
      .position  (pos_in),
      .height_mm (height_in)
   );

   always_comb begin
      rsp_in.step_out       = step_in;
      rsp_in.dir_out        = dir_in;
      rsp_in.driver_awake   = mode_in != MODE_IDLE;
      rsp_in.busy_res       = mode_in != MODE_IDLE;
      rsp_in.position_steps = pos_in;
      rsp_in.height_mm      = height_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_top_ff <= PERIOD_TOP_RESET;
         pulse_high_ff <= PULSE_HIGH_RESET;
         max_height_ff <= MAX_HEIGHT_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         mode_ff       <= MODE_IDLE;
         tick_ff       <= '0;
         pos_ff        <= '0;
         target_ff     <= '0;
         dir_ff        <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_PERIOD_TOP: period_top_ff <= csr_data;
               CSR_PULSE_HIGH: pulse_high_ff <= csr_data;
               CSR_MAX_HEIGHT: max_height_ff <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            mode_ff      <= mode_in;
            tick_ff      <= tick_in;
            pos_ff       <= pos_in;
            target_ff    <= target_in;
            dir_ff       <= dir_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

>>> verif/spc_position_checker.sv
// ----------------------------------------------------------------------------
// spc_position_checker
// Watches the request, response and register channels of the stepper
// position controller. It keeps its own copy of the motion state and the
// registers, predicts the status word for every accepted request word, and
// compares each accepted response word field by field with the oldest one
// still waiting.
// ----------------------------------------------------------------------------

module spc_position_checker
   import spc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire req_word_type           req_word,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rsp_word_type           rsp_word,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_W-1:0]       csr_data,
   output int                          error_count,
   output int                          pending_words
);

   localparam int REPORT_LIMIT = 10;

   typedef enum logic [1:0] {
      MOTION_IDLE,
      MOTION_HOMING,
      MOTION_MOVING
   } motion_state_type;

   logic [CSR_W-1:0]  period_top;
   logic [CSR_W-1:0]  pulse_high;
   logic [CSR_W-1:0]  max_height;

   motion_state_type  motion;
   logic [POS_W-1:0]  tick_count;
   logic [POS_W-1:0]  position;
   logic [POS_W-1:0]  target;
   logic              descending;

   rsp_word_type      expected_status[$];

   function automatic logic move_finished();
      if (!descending)
         return !(position < target && position < max_height);
      return !(position > target && position != '0);
   endfunction

   // one running tick, returns the step line level
   function automatic logic advance_tick();
      logic level;
      level = (tick_count < pulse_high);
      if (tick_count >= period_top) begin
         tick_count = '0;
         position = descending ? position - 1'b1 : position + 1'b1;
         if (motion == MOTION_MOVING && move_finished())
            motion = MOTION_IDLE;
      end else begin
         tick_count = tick_count + 1'b1;
      end
      return level;
   endfunction

   function automatic rsp_word_type next_status(input req_word_type w);
      rsp_word_type      r;
      logic [POS_W:0]    sum;
      logic [POS_W-1:0]  steps;
      logic              level;
      int unsigned       height;
      steps = POS_W'(w.distance_mm * SPC_STEPS_PER_MM);
      level = 1'b0;
      if (motion == MOTION_IDLE) begin
         if (w.action == ACTION_HOME) begin
            descending = 1'b1;
            tick_count = '0;
            if (w.limit_switch)
               position = '0;
            else
               motion = MOTION_HOMING;
         end else if (w.action == ACTION_MOVE) begin
            descending = w.move_down;
            tick_count = '0;
            if (!descending) begin
               sum = {1'b0, position} + {1'b0, steps};
               target = sum[POS_W] ? '1 : sum[POS_W-1:0];
            end else begin
               target = (steps >= position) ? '0 : position - steps;
            end
            if (!move_finished())
               motion = MOTION_MOVING;
         end
      end else if (w.action == ACTION_TICK) begin
         if (motion == MOTION_HOMING && w.limit_switch) begin
            position = '0;
            motion = MOTION_IDLE;
            tick_count = '0;
         end else begin
            level = advance_tick();
         end
      end
      height = position / SPC_STEPS_PER_MM;
      r.step_out = level;
      r.dir_out = descending;
      r.driver_awake = (motion != MOTION_IDLE);
      r.busy_res = (motion != MOTION_IDLE);
      r.position_steps = position;
      r.height_mm = (height > 255) ? '1 : HEIGHT_W'(height);
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_word_type want;
      string        bad;
      if (reset) begin
         period_top = PERIOD_TOP_RESET;
         pulse_high = PULSE_HIGH_RESET;
         max_height = MAX_HEIGHT_RESET;
         motion = MOTION_IDLE;
         tick_count = '0;
         position = '0;
         target = '0;
         descending = 1'b0;
         expected_status.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PERIOD_TOP: period_top = csr_data;
               CSR_PULSE_HIGH: pulse_high = csr_data;
               CSR_MAX_HEIGHT: max_height = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_status.push_back(next_status(req_word));
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: response word with none expected", $time);
            end else begin
               want = expected_status.pop_front();
               bad = "";
               if (rsp_word.step_out !== want.step_out)
                  bad = {bad, " step_out"};
               if (rsp_word.dir_out !== want.dir_out)
                  bad = {bad, " dir_out"};
               if (rsp_word.driver_awake !== want.driver_awake)
                  bad = {bad, " driver_awake"};
               if (rsp_word.busy_res !== want.busy_res)
                  bad = {bad, " busy_res"};
               if (rsp_word.position_steps !== want.position_steps)
                  bad = {bad, " position_steps"};
               if (rsp_word.height_mm !== want.height_mm)
                  bad = {bad, " height_mm"};
               if (bad != "") begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("%0t: response word mismatch in%s", $time, bad);
                     $display("   expected step %0b dir %0b awake %0b busy %0b pos %0d height %0d",
                              want.step_out, want.dir_out, want.driver_awake,
                              want.busy_res, want.position_steps, want.height_mm);
                     $display("   actual   step %0b dir %0b awake %0b busy %0b pos %0d height %0d",
                              rsp_word.step_out, rsp_word.dir_out, rsp_word.driver_awake,
                              rsp_word.busy_res, rsp_word.position_steps, rsp_word.height_mm);
                  end
               end
            end
         end
      end
      pending_words <= expected_status.size();
   end

endmodule

>>> verif/stepper_position_controller_core_test.sv
// ----------------------------------------------------------------------------
// stepper_position_controller_core_test
// Drives the stepper position controller with directed words covering idle
// ticks, ignored commands, homing, clamped and saturated moves and homing
// past zero so the position wraps, then with random command and tick
// sequences under several register settings and idle/stall mixes. A checker
// beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------

module stepper_position_controller_core_test;

   import spc_pkg::*;

   localparam int         QUIET_LIMIT = 2000;
   localparam logic [1:0] ACTION_NONE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_data = '0;

   int                    error_count;
   int                    pending_words;
   int                    req_idle_pct = 0;
   int                    rsp_stall_pct = 0;
   int                    quiet_cycles = 0;

   stepper_position_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   spc_position_checker position_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_words (pending_words)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog on cycles with no word moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input req_word_type w);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic issue(input logic [1:0] act, input logic down,
                        input logic [DIST_W-1:0] distance, input logic lim);
      req_word_type w;
      w.action = act;
      w.move_down = down;
      w.distance_mm = distance;
      w.limit_switch = lim;
      send_word(w);
   endtask

   task automatic random_tick();
      issue(ACTION_TICK, 1'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // hold the sender until every response word has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int           left;
      int           ticks;
      int           roll;
      logic [31:0]  noise_bits;
      req_word_type noise_word;
      left = count;
      while (left > 0) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            noise_bits = $urandom;
            noise_word = noise_bits[$bits(req_word_type)-1:0];
            send_word(noise_word);
            left--;
         end else begin
            if (roll < 35)
               issue(ACTION_HOME, 1'($urandom), 8'($urandom), $urandom_range(6) == 0);
            else
               issue(ACTION_MOVE, 1'($urandom),
                     ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3)),
                     1'($urandom));
            ticks = $urandom_range(80, 1);
            repeat (ticks) begin
               issue(($urandom_range(30) == 0) ? ACTION_MOVE : ACTION_TICK, 1'($urandom),
                     8'($urandom_range(3)), $urandom_range(24) == 0);
            end
            left -= ticks + 1;
         end
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct,
                            input logic [CSR_W-1:0] period, input logic [CSR_W-1:0] pulse,
                            input logic [CSR_W-1:0] top_steps, input int count);
      drain();
      write_reg(CSR_PERIOD_TOP, period);
      write_reg(CSR_PULSE_HIGH, pulse);
      write_reg(CSR_MAX_HEIGHT, top_steps);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      run_random(count);
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      issue(ACTION_TICK, 1'b0, 8'd0, 1'b0);
      issue(ACTION_NONE, 1'b1, 8'hFF, 1'b1);
      issue(ACTION_MOVE, 1'b0, 8'd0, 1'b0);
      issue(ACTION_MOVE, 1'b1, 8'hFF, 1'b0);
      issue(ACTION_HOME, 1'b0, 8'd0, 1'b1);
      issue(ACTION_HOME, 1'b1, 8'hAA, 1'b0);
      issue(ACTION_TICK, 1'b0, 8'd0, 1'b0);
      issue(ACTION_TICK, 1'b0, 8'd0, 1'b0);
      issue(ACTION_MOVE, 1'b0, 8'd3, 1'b0);
      issue(ACTION_HOME, 1'b0, 8'd0, 1'b1);
      issue(ACTION_NONE, 1'b0, 8'd0, 1'b1);
      issue(ACTION_TICK, 1'b0, 8'd0, 1'b1);
      issue(ACTION_MOVE, 1'b0, 8'd1, 1'b0);
      repeat (3) issue(ACTION_TICK, 1'b1, 8'h55, 1'b1);

      // shorten the period while the move is still running
      drain();
      write_reg(CSR_PERIOD_TOP, 16'd0);
      write_reg(CSR_PULSE_HIGH, 16'd1);
      write_reg(CSR_MAX_HEIGHT, 16'hFFFF);
      repeat (60) random_tick();

      // home past zero, position wraps to the top and the height saturates
      issue(ACTION_HOME, 1'b0, 8'd0, 1'b0);
      repeat (80) issue(ACTION_TICK, 1'b0, 8'd0, 1'b0);
      issue(ACTION_TICK, 1'b0, 8'd0, 1'b1);
      issue(ACTION_MOVE, 1'b0, 8'hFF, 1'b0);
      repeat (30) random_tick();
      issue(ACTION_MOVE, 1'b0, 8'd7, 1'b0);
      issue(ACTION_HOME, 1'b0, 8'd0, 1'b0);
      issue(ACTION_TICK, 1'b0, 8'd0, 1'b0);
      issue(ACTION_TICK, 1'b0, 8'd0, 1'b1);

      run_phase(0, 0, 16'd2, 16'd1, 16'd400, 250);
      run_phase(58, 0, 16'd0, 16'd0, 16'd120, 250);
      run_phase(0, 58, 16'd5, 16'hFFFF, 16'd0, 250);
      run_phase(16, 16, 16'd3, 16'd2, 16'd300, 250);
      run_phase(16, 16, 16'hFFFF, 16'hFFFF, 16'hFFFF, 60);
      drain();

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
